// ===== rtl/ray_quadratic_root_solver_macros.svh =====
// Assertion helpers for the solver RTL.
`ifndef RAY_QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define RAY_QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Plain check: expr must hold at every clock edge outside reset.
`define RQRS_CHECK(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rqrs check failed");

// Implication check: cond at an edge implies expr at the same edge.
`define RQRS_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rqrs implication failed");

`endif

// ===== rtl/rqrs_pkg.sv =====
package rqrs_pkg;

   localparam int WORD_BITS      = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DISC_BITS      = 2 * WORD_BITS + 1;
   localparam int ROOT_BITS      = WORD_BITS + 1;
   localparam int NUM_MAG_BITS   = WORD_BITS + 1;
   localparam int DEN_BITS       = WORD_BITS + 1;

   typedef enum logic [2:0] {
      ST_HIT_AHEAD   = 3'd0,
      ST_INSIDE      = 3'd1,
      ST_NEG_DISC    = 3'd2,
      ST_BEHIND      = 3'd3,
      ST_DEGENERATE  = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_a;
      logic signed [WORD_BITS-1:0] coef_b;
      logic signed [WORD_BITS-1:0] coef_c;
   } req_type;

   typedef struct packed {
      status_type                  hit_status;
      logic signed [WORD_BITS-1:0] near_distance;
      logic signed [WORD_BITS-1:0] far_distance;
   } rsp_type;

   // Travels alongside the square root pipeline.
   typedef struct packed {
      logic                 a_neg;
      logic [WORD_BITS-1:0] a_mag;
      logic                 b_neg;
      logic [WORD_BITS-1:0] b_mag;
      status_type           early_status;
      logic                 early_done;
   } sq_side_type;

   // Travels alongside the divider pipeline.
   typedef struct packed {
      status_type early_status;
      logic       early_done;
      logic       a_neg;
      logic       sign1;
      logic       sign2;
      logic       pos1;
      logic       pos2;
      logic       neg1;
      logic       neg2;
   } dv_side_type;

endpackage

// ===== rtl/ray_quadratic_root_solver.sv =====
// Channel   | Ports                  | Moves
// ----------+------------------------+-------------------------------------
// request   | start, busy, req_data  | one word of terms a, b, c
// response  | rsp_strobe, rsp_data   | one word of status, near, far
//
// One word may enter in every cycle outside reset; the result passes through
// the bit-per-stage square root (WORD_BITS+1 stages) and then the
// bit-per-stage divider (WORD_BITS+1+FRAC_BITS stages).
// Reset is synchronous and active high; it empties the pipeline, and busy is
// high only while reset is held. The receiver takes each result in the single
// cycle rsp_strobe is high; nothing stalls.
`include "ray_quadratic_root_solver_macros.svh"

module ray_quadratic_root_solver
   import rqrs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int W       = WORD_BITS;
   localparam int NUM_W   = NUM_MAG_BITS + FRAC_BITS;
   localparam int N_W     = W + 2;
   localparam int LATENCY = 2 * W + FRAC_BITS + 7;

   // accept every word outside reset
   logic take;
   assign busy = reset;
   assign take = start && !busy;

   // discriminant: split, multiply, combine
   logic                 d_valid;
   logic [DISC_BITS-1:0] d_disc;
   sq_side_type          d_side;

   rqrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_data   (req_data),
      .out_valid (d_valid),
      .out_disc  (d_disc),
      .out_side  (d_side)
   );

   // integer square root of the discriminant
   logic                 s_valid;
   logic [ROOT_BITS-1:0] s_root;
   sq_side_type          s_side;

   rqrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_disc   (d_disc),
      .in_side   (d_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // numerators -b - root and -b + root, signed, then classify the signs
   logic signed [N_W-1:0] mb, sv, n1, n2;
   logic [NUM_MAG_BITS-1:0] m1, m2;
   logic sg1, sg2, nz1, nz2;
   dv_side_type nside_in;

   always_comb begin
      mb  = s_side.b_neg ? $signed({2'b00, s_side.b_mag})
                         : -$signed({2'b00, s_side.b_mag});
      sv  = $signed({1'b0, s_root});
      n1  = mb - sv;
      n2  = mb + sv;
      m1  = n1[N_W-1] ? NUM_MAG_BITS'(-n1) : NUM_MAG_BITS'(n1);
      m2  = n2[N_W-1] ? NUM_MAG_BITS'(-n2) : NUM_MAG_BITS'(n2);
      nz1 = (m1 != '0);
      nz2 = (m2 != '0);
      sg1 = n1[N_W-1] ^ s_side.a_neg;
      sg2 = n2[N_W-1] ^ s_side.a_neg;
      nside_in.early_status = s_side.early_status;
      nside_in.early_done   = s_side.early_done;
      nside_in.a_neg        = s_side.a_neg;
      nside_in.sign1        = sg1;
      nside_in.sign2        = sg2;
      nside_in.pos1         = nz1 && !sg1;
      nside_in.pos2         = nz2 && !sg2;
      nside_in.neg1         = nz1 && sg1;
      nside_in.neg2         = nz2 && sg2;
   end

   logic                n_valid_ff;
   logic [NUM_W-1:0]    num1_ff, num2_ff;
   logic [DEN_BITS-1:0] den_ff;
   dv_side_type         nside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= s_valid;
      end
      // scale to the fraction point, divisor is twice |a|
      num1_ff  <= NUM_W'(m1) << FRAC_BITS;
      num2_ff  <= NUM_W'(m2) << FRAC_BITS;
      den_ff   <= {s_side.a_mag, 1'b0};
      nside_ff <= nside_in;
   end

   // both quotients, truncated toward zero
   logic             q_valid;
   logic [NUM_W-1:0] quo1, quo2;
   dv_side_type      q_side;

   rqrs_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid_ff),
      .in_num1   (num1_ff),
      .in_num2   (num2_ff),
      .in_den    (den_ff),
      .in_side   (nside_ff),
      .out_valid (q_valid),
      .out_quo1  (quo1),
      .out_quo2  (quo2),
      .out_side  (q_side)
   );

   // saturate to the signed word, then apply the sign
   function automatic logic [W-1:0] saturate(input logic [NUM_W-1:0] q,
                                              input logic neg);
      logic [NUM_W-1:0] lim;
      logic [W-1:0]     v;
      lim = neg ? (NUM_W'(1) << (W - 1)) : ((NUM_W'(1) << (W - 1)) - NUM_W'(1));
      v   = (q > lim) ? lim[W-1:0] : q[W-1:0];
      return neg ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
   endfunction

   logic [W-1:0] t1, t2;
   rsp_type      rsp_in;

   always_comb begin
      t1 = saturate(quo1, q_side.sign1);
      t2 = saturate(quo2, q_side.sign2);
      rsp_in.hit_status    = ST_INSIDE;
      rsp_in.near_distance = '0;
      rsp_in.far_distance  = '0;
      priority if (q_side.early_done) begin
         rsp_in.hit_status = q_side.early_status;
      end else if (q_side.neg1 && q_side.neg2) begin
         rsp_in.hit_status = ST_BEHIND;
      end else if (q_side.pos1 && q_side.pos2) begin
         rsp_in.hit_status    = ST_HIT_AHEAD;
         rsp_in.near_distance = q_side.a_neg ? t2 : t1;
         rsp_in.far_distance  = q_side.a_neg ? t1 : t2;
      end else begin
         // eye inside: report the larger root twice
         rsp_in.hit_status    = ST_INSIDE;
         rsp_in.near_distance = q_side.a_neg ? t1 : t2;
         rsp_in.far_distance  = q_side.a_neg ? t1 : t2;
      end
   end

   logic    strobe_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= q_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // every accepted word yields exactly one result;
   // history from before the first edge counts as no word taken
   `RQRS_CHECK(a_latency, clock, reset, rsp_strobe == ($past(take, LATENCY) === 1'b1))
   // no-hit results carry zero distances
   `RQRS_IMPLY(a_nohit_zero, clock, reset,
      rsp_strobe && (rsp_data.hit_status == ST_NEG_DISC ||
      rsp_data.hit_status == ST_BEHIND || rsp_data.hit_status == ST_DEGENERATE),
      rsp_data.near_distance == '0 && rsp_data.far_distance == '0)
   // two hits ahead come out ordered
   `RQRS_IMPLY(a_ordered, clock, reset,
      rsp_strobe && rsp_data.hit_status == ST_HIT_AHEAD,
      rsp_data.near_distance <= rsp_data.far_distance)

endmodule

// ===== rtl/rqrs_disc.sv =====
module rqrs_disc
   import rqrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  req_type              in_data,
   output logic                 out_valid,
   output logic [DISC_BITS-1:0] out_disc,
   output sq_side_type          out_side
);

   localparam int W = WORD_BITS;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
   endfunction

   // stage one: sign and magnitude
   logic         s1_valid_ff;
   logic         an_ff, bn_ff, cn_ff;
   logic [W-1:0] am_ff, bm_ff, cm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      an_ff <= in_data.coef_a[W-1];
      bn_ff <= in_data.coef_b[W-1];
      cn_ff <= in_data.coef_c[W-1];
      am_ff <= mag_of(in_data.coef_a);
      bm_ff <= mag_of(in_data.coef_b);
      cm_ff <= mag_of(in_data.coef_c);
   end

   // stage two: products
   logic           s2_valid_ff;
   logic [2*W-1:0] pbb_ff, pac_ff;
   sq_side_type    s2_side_ff;
   logic           s2_cn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      pbb_ff <= bm_ff * bm_ff;
      pac_ff <= am_ff * cm_ff;
      s2_cn_ff <= cn_ff;
      s2_side_ff.a_neg <= an_ff;
      s2_side_ff.a_mag <= am_ff;
      s2_side_ff.b_neg <= bn_ff;
      s2_side_ff.b_mag <= bm_ff;
      s2_side_ff.early_status <= ST_DEGENERATE;
      s2_side_ff.early_done <= (am_ff == '0);
   end

   // stage three: discriminant
   logic [DISC_BITS-1:0] p_ext, q4;
   logic                 disc_neg;
   logic [DISC_BITS-1:0] disc_in;
   sq_side_type          side_in;
   logic                 out_valid_ff;
   logic [DISC_BITS-1:0] disc_ff;
   sq_side_type          side_ff;

   always_comb begin
      p_ext    = {1'b0, pbb_ff};
      q4       = {pac_ff[2*W-2:0], 2'b00};
      disc_neg = (s2_side_ff.a_neg == s2_cn_ff) && (p_ext < q4);
      disc_in  = (s2_side_ff.a_neg != s2_cn_ff) ? p_ext + q4 : p_ext - q4;
      side_in  = s2_side_ff;
      if (!s2_side_ff.early_done && disc_neg) begin
         side_in.early_done   = 1'b1;
         side_in.early_status = ST_NEG_DISC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s2_valid_ff;
      end
      disc_ff <= disc_in;
      side_ff <= side_in;
   end

   assign out_valid = out_valid_ff;
   assign out_disc  = disc_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/rqrs_sqrt.sv =====
module rqrs_sqrt
   import rqrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DISC_BITS-1:0] in_disc,
   input  sq_side_type          in_side,
   output logic                 out_valid,
   output logic [ROOT_BITS-1:0] out_root,
   output sq_side_type          out_side
);

   localparam int R     = ROOT_BITS;
   localparam int RAD_W = 2 * R;
   localparam int REM_W = R + 3;

   logic             valid_ff [R];
   logic [RAD_W-1:0] rad_ff   [R];
   logic [REM_W-1:0] rem_ff   [R];
   logic [R-1:0]     root_ff  [R];
   sq_side_type      side_ff  [R];

   // one root bit per stage
   for (genvar g = 0; g < R; g++) begin : g_stage
      logic             v_cur;
      logic [RAD_W-1:0] rad_cur;
      logic [REM_W-1:0] rem_cur;
      logic [R-1:0]     root_cur;
      sq_side_type      side_cur;
      logic [REM_W-1:0] rem_sh, trial, rem_in;
      logic             ge;

      if (g == 0) begin : g_first
         assign v_cur    = in_valid;
         assign rad_cur  = {{(RAD_W-DISC_BITS){1'b0}}, in_disc};
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = valid_ff[g-1];
         assign rad_cur  = rad_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
         assign side_cur = side_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
         trial  = {1'b0, root_cur, 2'b01};
         ge     = (rem_sh >= trial);
         rem_in = ge ? rem_sh - trial : rem_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_cur;
         end
         rad_ff[g]  <= {rad_cur[RAD_W-3:0], 2'b00};
         rem_ff[g]  <= rem_in;
         root_ff[g] <= {root_cur[R-2:0], ge};
         side_ff[g] <= side_cur;
      end
   end

   assign out_valid = valid_ff[R-1];
   assign out_root  = root_ff[R-1];
   assign out_side  = side_ff[R-1];

endmodule

// ===== rtl/rqrs_div.sv =====
module rqrs_div
   import rqrs_pkg::*;
#(
   parameter int NUM_W = NUM_MAG_BITS + FRAC_BITS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num1,
   input  logic [NUM_W-1:0]    in_num2,
   input  logic [DEN_BITS-1:0] in_den,
   input  dv_side_type         in_side,
   output logic                out_valid,
   output logic [NUM_W-1:0]    out_quo1,
   output logic [NUM_W-1:0]    out_quo2,
   output dv_side_type         out_side
);

   localparam int D = DEN_BITS;

   logic            valid_ff [NUM_W];
   logic [D-1:0]    den_ff   [NUM_W];
   dv_side_type     side_ff  [NUM_W];
   logic [NUM_W-1:0] num_ff  [NUM_W][2];
   logic [D-1:0]     rem_ff  [NUM_W][2];
   logic [NUM_W-1:0] quo_ff  [NUM_W][2];

   // one quotient bit per stage, both roots share the divisor
   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic        v_cur;
      logic [D-1:0] den_cur;
      dv_side_type side_cur;

      if (g == 0) begin : g_first
         assign v_cur    = in_valid;
         assign den_cur  = in_den;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = valid_ff[g-1];
         assign den_cur  = den_ff[g-1];
         assign side_cur = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_cur;
         end
         den_ff[g]  <= den_cur;
         side_ff[g] <= side_cur;
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [NUM_W-1:0] num_cur, quo_cur;
         logic [D-1:0]     rem_cur;
         logic [D:0]       rsh, diff;
         logic             ge;

         if (g == 0) begin : g_first
            assign num_cur = (l == 0) ? in_num1 : in_num2;
            assign rem_cur = '0;
            assign quo_cur = '0;
         end else begin : g_next
            assign num_cur = num_ff[g-1][l];
            assign rem_cur = rem_ff[g-1][l];
            assign quo_cur = quo_ff[g-1][l];
         end

         always_comb begin
            rsh  = {rem_cur, num_cur[NUM_W-1]};
            diff = rsh - {1'b0, den_cur};
            ge   = (rsh >= {1'b0, den_cur});
         end

         always_ff @(posedge clock) begin
            num_ff[g][l] <= {num_cur[NUM_W-2:0], 1'b0};
            rem_ff[g][l] <= ge ? diff[D-1:0] : rsh[D-1:0];
            quo_ff[g][l] <= {quo_cur[NUM_W-2:0], ge};
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo1  = quo_ff[NUM_W-1][0];
   assign out_quo2  = quo_ff[NUM_W-1][1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
